// ===== sv/e2q_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the euler angle to quaternion pipeline
// no dependencies

package e2q_pkg;

   localparam int CORDIC_STEPS    = 30;
   localparam int STEPS_PER_STAGE = 3;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
   localparam int PHASE_LAT       = 3;
   localparam int CORDIC_LAT      = CORDIC_STAGES + 1;
   localparam int QUAT_LAT        = 4;
   localparam int TOTAL_LAT       = PHASE_LAT + CORDIC_LAT + QUAT_LAT;
   localparam int FLAG_LAT        = TOTAL_LAT - 1;

   // sine/cosine width (q2.30 with headroom for +-1.0), cordic datapath widths
   localparam int CW     = 32;
   localparam int XW     = 34;
   localparam int ZW     = 32;
   // one turn of the half angle is 46080 units = 45 * 2^10
   localparam int FRAC_W   = 22;
   localparam int TURN_DIV = 45;

   localparam logic signed [XW-1:0] CORDIC_X0 = 34'sh0_26DD_3B6A;
   localparam logic signed [CW-1:0] ONE_Q30   = 32'sh4000_0000;

   typedef logic signed [ZW-1:0] atan_tbl_type [CORDIC_STEPS];

   localparam atan_tbl_type ATAN_TBL = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
   };

   typedef logic [FRAC_W-1:0] frac_tbl_type [TURN_DIV];

   // low phase bits for each remainder of the angle modulo 45
   function automatic frac_tbl_type build_frac_tbl();
      frac_tbl_type tbl;
      for (int i = 0; i < TURN_DIV; i++) begin
         tbl[i] = FRAC_W'((longint'(i) << FRAC_W) / TURN_DIV);
      end
      return tbl;
   endfunction

   localparam frac_tbl_type FRAC_TBL = build_frac_tbl();

   typedef struct packed {
      logic [1:0]           quad;
      logic signed [ZW-1:0] resid;
   } phase_type;

   typedef struct packed {
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] s;
   } sincos_type;

endpackage

// ===== sv/e2q_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces, valid/ready handshake
// no dependencies

interface e2q_req_if #(parameter int ANGLE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] pitch_deg;
   logic signed [ANGLE_WIDTH-1:0] heading_deg;
   logic signed [ANGLE_WIDTH-1:0] bank_deg;
   logic                          object_to_inertial;

   modport source(output valid, pitch_deg, heading_deg, bank_deg, object_to_inertial,
                  input ready);
   modport sink(input valid, pitch_deg, heading_deg, bank_deg, object_to_inertial,
                output ready);
endinterface

interface e2q_rsp_if #(parameter int QW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] quat_w;
   logic signed [QW-1:0] quat_x;
   logic signed [QW-1:0] quat_y;
   logic signed [QW-1:0] quat_z;

   modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== sv/e2q_phase.sv =====
`timescale 1ns / 1ps
// angle in 1/64 degree to 32-bit half-angle phase, quadrant and residual
// depends on e2q_pkg

module e2q_phase
   import e2q_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output phase_type                     phase
);

   // offset by 45 * 2^(w-1) keeps the value positive and leaves m mod 1024 alone
   localparam int NW    = ANGLE_WIDTH + 5;
   localparam int SHIFT = NW + 6;
   localparam int RW    = NW + 1;
   localparam int PW    = NW + RW;
   localparam int MW    = PW - SHIFT;
   localparam longint unsigned OFFSET = longint'(TURN_DIV) * (64'd1 << (ANGLE_WIDTH - 1));
   localparam longint unsigned RECIP  = (64'd1 << SHIFT) / TURN_DIV;

   logic [NW:0]    ext;
   logic [NW-1:0]  aoff_in, aoff_ff;
   logic [PW-1:0]  prod_in, prod_ff;
   logic [MW-1:0]  m_est;
   logic [6:0]     t_raw;
   logic           ge;
   logic [9:0]     m_in, m_ff;
   logic [5:0]     t_in, t_ff;
   logic [31:0]    ph;
   logic [1:0]     quad;
   phase_type      phase_in, phase_ff;

   // stage 1: offset and reciprocal multiply
   always_comb begin
      ext     = (NW + 1)'(angle) + (NW + 1)'(OFFSET);
      aoff_in = ext[NW-1:0];
      prod_in = PW'(aoff_in) * PW'(RECIP);
   end

   // stage 2: quotient estimate, remainder and one correction step
   always_comb begin
      m_est = prod_ff[PW-1:SHIFT];
      t_raw = aoff_ff[6:0] - 7'(m_est[6:0] * 7'(TURN_DIV));
      ge    = (t_raw >= 7'(TURN_DIV));
      t_in  = ge ? 6'(t_raw - 7'(TURN_DIV)) : t_raw[5:0];
      m_in  = m_est[9:0] + 10'(ge);
   end

   // stage 3: phase, nearest quadrant, signed residual
   always_comb begin
      ph             = {m_ff, FRAC_TBL[t_ff]};
      quad           = 2'((ph + 32'h2000_0000) >> 30);
      phase_in.quad  = quad;
      phase_in.resid = signed'(ph - {quad, 30'd0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aoff_ff  <= aoff_in;
         prod_ff  <= prod_in;
         m_ff     <= m_in;
         t_ff     <= t_in;
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ===== sv/e2q_cordic.sv =====
`timescale 1ns / 1ps
// pipelined rotation-mode cordic, three steps per stage, then clamp and quadrant
// depends on e2q_pkg

module e2q_cordic
   import e2q_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  phase_type  phase_in,
   output sincos_type sc
);

   logic signed [XW-1:0] x_ff [CORDIC_STAGES];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES];
   logic [1:0]           q_ff [CORDIC_STAGES];

   sincos_type sc_in, sc_ff;

   function automatic logic signed [CW-1:0] clamp(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] one;
      one = XW'(ONE_Q30);
      if (v > one) begin
         return ONE_Q30;
      end else if (v < -one) begin
         return -ONE_Q30;
      end
      return CW'(v);
   endfunction

   genvar s;
   for (s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      logic signed [XW-1:0] xs [STEPS_PER_STAGE+1];
      logic signed [XW-1:0] ys [STEPS_PER_STAGE+1];
      logic signed [ZW-1:0] zs [STEPS_PER_STAGE+1];
      logic [1:0]           qs;

      if (s == 0) begin : g_first
         assign xs[0] = CORDIC_X0;
         assign ys[0] = '0;
         assign zs[0] = phase_in.resid;
         assign qs    = phase_in.quad;
      end else begin : g_next
         assign xs[0] = x_ff[s-1];
         assign ys[0] = y_ff[s-1];
         assign zs[0] = z_ff[s-1];
         assign qs    = q_ff[s-1];
      end

      for (genvar k = 0; k < STEPS_PER_STAGE; k++) begin : g_step
         localparam int I = s * STEPS_PER_STAGE + k;
         always_comb begin
            if (!zs[k][ZW-1]) begin
               xs[k+1] = xs[k] - (ys[k] >>> I);
               ys[k+1] = ys[k] + (xs[k] >>> I);
               zs[k+1] = zs[k] - ATAN_TBL[I];
            end else begin
               xs[k+1] = xs[k] + (ys[k] >>> I);
               ys[k+1] = ys[k] - (xs[k] >>> I);
               zs[k+1] = zs[k] + ATAN_TBL[I];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s] <= xs[STEPS_PER_STAGE];
            y_ff[s] <= ys[STEPS_PER_STAGE];
            z_ff[s] <= zs[STEPS_PER_STAGE];
            q_ff[s] <= qs;
         end
      end
   end

   // clamp to +-1.0 and rotate back by the quadrant
   always_comb begin
      logic signed [CW-1:0] cs, sn;
      cs = clamp(x_ff[CORDIC_STAGES-1]);
      sn = clamp(y_ff[CORDIC_STAGES-1]);
      unique case (q_ff[CORDIC_STAGES-1])
         2'd0: begin
            sc_in.c = cs;
            sc_in.s = sn;
         end
         2'd1: begin
            sc_in.c = -sn;
            sc_in.s = cs;
         end
         2'd2: begin
            sc_in.c = -cs;
            sc_in.s = -sn;
         end
         default: begin
            sc_in.c = sn;
            sc_in.s = -cs;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
      end
   end

   assign sc = sc_ff;

endmodule

// ===== sv/e2q_quat.sv =====
`timescale 1ns / 1ps
// product tree, sums, rounding, saturation and conjugation of the quaternion
// depends on e2q_pkg

module e2q_quat
   import e2q_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                           clock,
   input  logic                           en,
   input  sincos_type                     pitch,
   input  sincos_type                     heading,
   input  sincos_type                     bank,
   input  logic                           conj,
   output logic signed [QUAT_FRAC_BITS+1:0] quat_w,
   output logic signed [QUAT_FRAC_BITS+1:0] quat_x,
   output logic signed [QUAT_FRAC_BITS+1:0] quat_y,
   output logic signed [QUAT_FRAC_BITS+1:0] quat_z
);

   localparam int QW = QUAT_FRAC_BITS + 2;
   localparam int SH = 30 - QUAT_FRAC_BITS;
   localparam longint RND = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
   localparam longint ONE = 64'sd1 <<< QUAT_FRAC_BITS;

   logic signed [CW-1:0] chcp_ff, chsp_ff, shsp_ff, shcp_ff, cb_ff, sb_ff;
   logic signed [CW-1:0] t_chcp_cb_ff, t_shsp_sb_ff, t_chsp_cb_ff, t_shcp_sb_ff;
   logic signed [CW-1:0] t_chsp_sb_ff, t_shcp_cb_ff, t_shsp_cb_ff, t_chcp_sb_ff;
   logic signed [CW:0]   w_sum_ff, x_sum_ff, y_sum_ff, z_sum_ff;
   logic signed [QW-1:0] w_in, x_in, y_in, z_in;
   logic signed [QW-1:0] w_ff, x_ff, y_ff, z_ff;

   // q30 product with floor shift
   function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      return p[CW+29:30];
   endfunction

   // round half up to the output fraction, then saturate to +-1.0
   function automatic logic signed [QW-1:0] to_out(input logic signed [CW:0] v);
      logic signed [CW+1:0] r;
      r = ((CW + 2)'(v) + (CW + 2)'(RND)) >>> SH;
      if (r > (CW + 2)'(ONE)) begin
         return QW'(ONE);
      end else if (r < -(CW + 2)'(ONE)) begin
         return -QW'(ONE);
      end
      return QW'(r);
   endfunction

   always_comb begin
      w_in = to_out(w_sum_ff);
      x_in = to_out(x_sum_ff);
      y_in = to_out(y_sum_ff);
      z_in = to_out(z_sum_ff);
      if (conj) begin
         x_in = -x_in;
         y_in = -y_in;
         z_in = -z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chcp_ff      <= mulq(heading.c, pitch.c);
         chsp_ff      <= mulq(heading.c, pitch.s);
         shsp_ff      <= mulq(heading.s, pitch.s);
         shcp_ff      <= mulq(heading.s, pitch.c);
         cb_ff        <= bank.c;
         sb_ff        <= bank.s;
         t_chcp_cb_ff <= mulq(chcp_ff, cb_ff);
         t_shsp_sb_ff <= mulq(shsp_ff, sb_ff);
         t_chsp_cb_ff <= mulq(chsp_ff, cb_ff);
         t_shcp_sb_ff <= mulq(shcp_ff, sb_ff);
         t_chsp_sb_ff <= mulq(chsp_ff, sb_ff);
         t_shcp_cb_ff <= mulq(shcp_ff, cb_ff);
         t_shsp_cb_ff <= mulq(shsp_ff, cb_ff);
         t_chcp_sb_ff <= mulq(chcp_ff, sb_ff);
         w_sum_ff     <= (CW + 1)'(t_chcp_cb_ff) + (CW + 1)'(t_shsp_sb_ff);
         x_sum_ff     <= -(CW + 1)'(t_chsp_cb_ff) - (CW + 1)'(t_shcp_sb_ff);
         y_sum_ff     <= (CW + 1)'(t_chsp_sb_ff) - (CW + 1)'(t_shcp_cb_ff);
         z_sum_ff     <= (CW + 1)'(t_shsp_cb_ff) - (CW + 1)'(t_chcp_sb_ff);
         w_ff         <= w_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
      end
   end

   assign quat_w = w_ff;
   assign quat_x = x_ff;
   assign quat_y = y_ff;
   assign quat_z = z_ff;

endmodule

// ===== sv/euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// pipeline: 3 phase, 11 cordic and 4 product stages from request beat to response beat
// throughput: one beat per cycle; the whole pipeline holds while a response beat
// waits unclaimed, set by the single stage-enable shared by all stages
// reset: synchronous, active high; clears the valid bits only, data stages are not reset
// depends on e2q_pkg, e2q_if, e2q_phase, e2q_cordic, e2q_quat

module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int ANGLE_WIDTH    = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic     clock,
   input  logic     reset,
   e2q_req_if.sink  req,
   e2q_rsp_if.source rsp
);

   // valid bits travel alongside the data through every stage
   logic [TOTAL_LAT-1:0] vld_ff, vld_in;
   // conjugate flag, delayed to meet the output rounding stage
   logic [FLAG_LAT-1:0]  flag_ff, flag_in;
   logic                 en;

   phase_type  ph_pitch, ph_heading, ph_bank;
   sincos_type sc_pitch, sc_heading, sc_bank;

   // advance when the output register is empty or being drained
   assign en        = !vld_ff[TOTAL_LAT-1] || rsp.ready;
   assign req.ready = en;

   always_comb begin
      vld_in  = {vld_ff[TOTAL_LAT-2:0], req.valid};
      flag_in = {flag_ff[FLAG_LAT-2:0], req.object_to_inertial};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff <= flag_in;
      end
   end

   // angle to phase, one lane per angle
   e2q_phase #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_phase_pitch (
      .clock (clock),
      .en    (en),
      .angle (req.pitch_deg),
      .phase (ph_pitch)
   );

   e2q_phase #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_phase_heading (
      .clock (clock),
      .en    (en),
      .angle (req.heading_deg),
      .phase (ph_heading)
   );

   e2q_phase #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_phase_bank (
      .clock (clock),
      .en    (en),
      .angle (req.bank_deg),
      .phase (ph_bank)
   );

   // half-angle sine and cosine
   e2q_cordic u_cordic_pitch (
      .clock    (clock),
      .en       (en),
      .phase_in (ph_pitch),
      .sc       (sc_pitch)
   );

   e2q_cordic u_cordic_heading (
      .clock    (clock),
      .en       (en),
      .phase_in (ph_heading),
      .sc       (sc_heading)
   );

   e2q_cordic u_cordic_bank (
      .clock    (clock),
      .en       (en),
      .phase_in (ph_bank),
      .sc       (sc_bank)
   );

   // products, sums and output formatting; last stage is the output register
   e2q_quat #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_quat (
      .clock   (clock),
      .en      (en),
      .pitch   (sc_pitch),
      .heading (sc_heading),
      .bank    (sc_bank),
      .conj    (flag_ff[FLAG_LAT-1]),
      .quat_w  (rsp.quat_w),
      .quat_x  (rsp.quat_x),
      .quat_y  (rsp.quat_y),
      .quat_z  (rsp.quat_z)
   );

   assign rsp.valid = vld_ff[TOTAL_LAT-1];

endmodule

// ===== sv/e2q_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the top level, attached by bind
// depends on euler_to_quaternion

module e2q_checker #(
   parameter int QW = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [QW-1:0] quat_w,
   input logic signed [QW-1:0] quat_x,
   input logic signed [QW-1:0] quat_y,
   input logic signed [QW-1:0] quat_z
);

   localparam logic signed [QW-1:0] ONE = QW'(1) <<< (QW - 2);

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(quat_w) && $stable(quat_x)
         && $stable(quat_y) && $stable(quat_z))
      else $error("response beat changed while stalled");

   // a stalled response stalls the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // nothing comes out right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every component within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> quat_w <= ONE && quat_w >= -ONE && quat_x <= ONE && quat_x >= -ONE
         && quat_y <= ONE && quat_y >= -ONE && quat_z <= ONE && quat_z >= -ONE)
      else $error("quaternion component out of range");

endmodule

bind euler_to_quaternion e2q_checker #(.QW(QUAT_FRAC_BITS + 2)) u_e2q_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .quat_w    (rsp.quat_w),
   .quat_x    (rsp.quat_x),
   .quat_y    (rsp.quat_y),
   .quat_z    (rsp.quat_z)
);
